FILE: src/swa_pkg.sv
package swa_pkg;

  localparam int MAX_QUERY     = 1024;
  localparam int ALPHABET_SIZE = 24;
  localparam int SCORE_BITS    = 16;

  localparam int CODE_W    = 5;
  localparam int SUBST_W   = 8;
  localparam int GAP_W     = 7;
  localparam int REF_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int QIDX_W    = $clog2(MAX_QUERY);
  localparam int QLEN_W    = QIDX_W + 1;
  localparam int SUB_AW    = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);
  localparam int CNT_W     = SCORE_BITS - 1;

  localparam logic signed [SCORE_BITS-1:0] SC_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SC_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [GAP_W-1:0] GAP_OPEN_RST = GAP_W'(10);
  localparam logic [GAP_W-1:0] GAP_EXT_RST  = GAP_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXT  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_MATRIX = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_REF    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDQ,
    ST_RDS,
    ST_CALC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic [CNT_W-1:0]             match_cnt;
    logic [CNT_W-1:0]             similar;
    logic [CNT_W-1:0]             length;
  } path_t;

  localparam path_t PATH_NONE = '{score: SC_MIN, match_cnt: '0, similar: '0, length: '0};

  typedef struct packed {
    path_t                        path;
    logic signed [SCORE_BITS-1:0] gap;
  } col_t;

  typedef struct packed {
    path_t                        diag;
    path_t                        up;
    logic signed [SCORE_BITS-1:0] vgap;
    col_t                         left;
    logic signed [SUBST_W-1:0]    sub;
    logic                         ident;
    logic [GAP_W-1:0]             gap_open;
    logic [GAP_W-1:0]             gap_ext;
  } cell_in_t;

  typedef struct packed {
    path_t                        path;
    logic signed [SCORE_BITS-1:0] hgap;
    logic signed [SCORE_BITS-1:0] vgap;
    logic                         sat;
  } cell_out_t;

endpackage

FILE: src/swa_if.sv
interface swa_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [swa_pkg::CODE_W-1:0]          residue;
  logic [swa_pkg::CODE_W-1:0]          matrix_col;
  logic signed [swa_pkg::SUBST_W-1:0]  matrix_value;
  logic                                last;

  modport source (output valid, mode, residue, matrix_col, matrix_value, last, input ready);
  modport sink (input valid, mode, residue, matrix_col, matrix_value, last, output ready);
endinterface

interface swa_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [swa_pkg::SCORE_BITS-1:0] score;
  logic [swa_pkg::CNT_W-1:0]             matches_res;
  logic [swa_pkg::CNT_W-1:0]             similar;
  logic [swa_pkg::CNT_W-1:0]             align_length;
  logic [swa_pkg::QIDX_W-1:0]            end_qpos;
  logic [swa_pkg::REF_W-1:0]             end_ref;
  logic                                  saturated;

  modport source (output valid, score, matches_res, similar, align_length, end_qpos, end_ref,
                  saturated, input ready);
  modport sink (input valid, score, matches_res, similar, align_length, end_qpos, end_ref,
                saturated, output ready);
endinterface

interface swa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [swa_pkg::CFG_IDX_W-1:0]     index;
  logic [swa_pkg::GAP_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/swa_ram.sv
module swa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/swa_cell.sv
module swa_cell (
  input  swa_pkg::cell_in_t  cell_i,
  output swa_pkg::cell_out_t cell_o
);

  localparam int W = swa_pkg::SCORE_BITS + 2;

  logic signed [W-1:0] hi, lo, open_s, ext_s;
  logic signed [W-1:0] dia, a_v, b_v, v, a_g, b_g, g, h;
  logic [swa_pkg::CNT_W:0] m, s, l, cmax;
  logic sat;

  always_comb begin
    hi     = W'(swa_pkg::SC_MAX);
    lo     = W'(swa_pkg::SC_MIN);
    open_s = W'(cell_i.gap_open);
    ext_s  = W'(cell_i.gap_ext);
    cmax   = {1'b0, swa_pkg::CNT_MAX};

    dia = W'(cell_i.diag.score) + W'(cell_i.sub);
    if (dia > hi) dia = hi;

    a_v = W'(cell_i.up.score) - open_s;
    if (a_v < lo) a_v = lo;
    b_v = W'(cell_i.vgap) - ext_s;
    if (b_v < lo) b_v = lo;
    v = (a_v > b_v) ? a_v : b_v;

    a_g = W'(cell_i.left.path.score) - open_s;
    if (a_g < lo) a_g = lo;
    b_g = W'(cell_i.left.gap) - ext_s;
    if (b_g < lo) b_g = lo;
    g = (a_g > b_g) ? a_g : b_g;

    h = dia;
    if (v > h) h = v;
    if (g > h) h = g;
    if (h < 0) h = '0;

    if (dia >= v && dia >= g) begin
      m = {1'b0, cell_i.diag.match_cnt} + (swa_pkg::CNT_W+1)'(cell_i.ident);
      s = {1'b0, cell_i.diag.similar} + (swa_pkg::CNT_W+1)'(cell_i.sub > 0);
      l = {1'b0, cell_i.diag.length} + 1'b1;
    end else if (v >= g) begin
      m = {1'b0, cell_i.up.match_cnt};
      s = {1'b0, cell_i.up.similar};
      l = {1'b0, cell_i.up.length} + 1'b1;
    end else begin
      m = {1'b0, cell_i.left.path.match_cnt};
      s = {1'b0, cell_i.left.path.similar};
      l = {1'b0, cell_i.left.path.length} + 1'b1;
    end
    if (h == 0) begin
      m = '0;
      s = '0;
      l = '0;
    end

    sat = 1'b0;
    if (h >= hi) begin
      h = hi;
      sat = 1'b1;
    end
    if (m >= cmax) begin
      m = cmax;
      sat = 1'b1;
    end
    if (s >= cmax) begin
      s = cmax;
      sat = 1'b1;
    end
    if (l >= cmax) begin
      l = cmax;
      sat = 1'b1;
    end

    cell_o.path.score     = h[swa_pkg::SCORE_BITS-1:0];
    cell_o.path.match_cnt = m[swa_pkg::CNT_W-1:0];
    cell_o.path.similar   = s[swa_pkg::CNT_W-1:0];
    cell_o.path.length    = l[swa_pkg::CNT_W-1:0];
    cell_o.hgap           = g[swa_pkg::SCORE_BITS-1:0];
    cell_o.vgap           = v[swa_pkg::SCORE_BITS-1:0];
    cell_o.sat            = sat;
  end

endmodule

FILE: src/smith_waterman_affine_stats_core.sv
// Local alignment engine with affine gaps and path statistics.
// Input beats arrive on in_if. A matrix beat writes one substitution entry when both
// codes are below ALPHABET_SIZE, and a query beat appends one residue while the query
// is not full; in_if.ready stays high for both. A reference beat computes one column of
// the score table, one query row at a time on a single cell unit. After it is taken,
// in_if.ready stays low while the block reads the first query residue, then for each
// row does the registered read of the substitution store and runs the cell, and then
// passes a closing state; an empty query goes straight to the closing state. A new
// input beat is thus taken only after the previous reference beat is through.
// A reference beat with last set produces one result beat on out_if, which becomes
// valid once the closing state loads it and is held in an output register until
// taken; the query, column and best-cell state clear when it is loaded. If the
// previous result is still waiting, the block stays in its closing state and accepts
// no further input beat until out_if.ready frees the register.
// cfg_if writes the gap open and gap extend penalties; it is always ready.
// Reset sets the penalties to 10 and 1, empties the query and best cell, and
// leaves the substitution matrix unwritten. Column state needs no clearing pass:
// rows beyond those already computed read as fresh rows.
module smith_waterman_affine_stats_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  swa_in_if.sink        in_if,
  swa_out_if.source     out_if,
  swa_cfg_if.sink       cfg_if
);

  swa_pkg::state_e state_q, state_d;

  logic [swa_pkg::GAP_W-1:0]         gap_open_q, gap_ext_q;
  logic [swa_pkg::QLEN_W-1:0]        qlen_q, rows_init_q;
  logic [swa_pkg::QIDX_W-1:0]        row_q;
  logic [swa_pkg::REF_W-1:0]         ref_pos_q;
  logic [swa_pkg::CODE_W-1:0]        r_q;
  logic                              last_q;
  swa_pkg::path_t                    diag_q, up_q;
  logic signed [swa_pkg::SCORE_BITS-1:0] vgap_q;
  swa_pkg::path_t                    best_q;
  logic [swa_pkg::QIDX_W-1:0]        best_row_q;
  logic [swa_pkg::REF_W-1:0]         best_ref_q;
  logic                              sat_q;
  logic                              out_valid_q;

  logic in_fire, out_free, row_last, row_valid, emit;

  logic                              q_we, q_re;
  logic [swa_pkg::QIDX_W-1:0]        q_raddr;
  logic [swa_pkg::CODE_W-1:0]        q_rdata;
  logic                              s_we, s_re;
  logic [swa_pkg::SUB_AW-1:0]        s_waddr, s_raddr;
  logic [swa_pkg::SUBST_W-1:0]       s_rdata;
  logic                              c_we;
  swa_pkg::col_t                     c_wdata, c_rdata, left;
  swa_pkg::cell_in_t                 cin;
  swa_pkg::cell_out_t                cout;

  assign in_fire   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_q || out_if.ready;
  assign row_last  = ({1'b0, row_q} + swa_pkg::QLEN_W'(1)) == qlen_q;
  assign row_valid = {1'b0, row_q} < rows_init_q;
  assign emit      = (state_q == swa_pkg::ST_FIN) && last_q && out_free;

  assign in_if.ready  = (state_q == swa_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign q_we    = in_fire && (swa_pkg::mode_e'(in_if.mode) == swa_pkg::MODE_QUERY)
                   && (qlen_q < swa_pkg::QLEN_W'(swa_pkg::MAX_QUERY));
  assign q_re    = (state_q == swa_pkg::ST_RDQ) || ((state_q == swa_pkg::ST_CALC) && !row_last);
  assign q_raddr = (state_q == swa_pkg::ST_RDQ) ? row_q : row_q + swa_pkg::QIDX_W'(1);

  assign s_we    = in_fire && (swa_pkg::mode_e'(in_if.mode) == swa_pkg::MODE_MATRIX)
                   && (in_if.residue < swa_pkg::CODE_W'(swa_pkg::ALPHABET_SIZE))
                   && (in_if.matrix_col < swa_pkg::CODE_W'(swa_pkg::ALPHABET_SIZE));
  assign s_waddr = swa_pkg::SUB_AW'(swa_pkg::SUB_AW'(in_if.residue)
                   * swa_pkg::SUB_AW'(swa_pkg::ALPHABET_SIZE)
                   + swa_pkg::SUB_AW'(in_if.matrix_col));
  assign s_re    = (state_q == swa_pkg::ST_RDS);
  assign s_raddr = swa_pkg::SUB_AW'(swa_pkg::SUB_AW'(q_rdata)
                   * swa_pkg::SUB_AW'(swa_pkg::ALPHABET_SIZE) + swa_pkg::SUB_AW'(r_q));

  assign c_we = (state_q == swa_pkg::ST_CALC);

  swa_ram #(.DEPTH(swa_pkg::MAX_QUERY), .WIDTH(swa_pkg::CODE_W)) u_query (
    .clk_i, .we_i(q_we), .waddr_i(qlen_q[swa_pkg::QIDX_W-1:0]), .wdata_i(in_if.residue),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  swa_ram #(.DEPTH(swa_pkg::ALPHABET_SIZE * swa_pkg::ALPHABET_SIZE),
            .WIDTH(swa_pkg::SUBST_W)) u_subst (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(in_if.matrix_value),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  swa_ram #(.DEPTH(swa_pkg::MAX_QUERY), .WIDTH($bits(swa_pkg::col_t))) u_col (
    .clk_i, .we_i(c_we), .waddr_i(row_q), .wdata_i(c_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(c_rdata)
  );

  always_comb begin
    if (row_valid) begin
      left = c_rdata;
    end else begin
      left = '0;
      left.gap = swa_pkg::SC_MIN;
    end
    cin.diag     = diag_q;
    cin.up       = up_q;
    cin.vgap     = vgap_q;
    cin.left     = left;
    cin.ident    = (q_rdata == r_q);
    cin.gap_open = gap_open_q;
    cin.gap_ext  = gap_ext_q;
    if (q_rdata < swa_pkg::CODE_W'(swa_pkg::ALPHABET_SIZE)
        && r_q < swa_pkg::CODE_W'(swa_pkg::ALPHABET_SIZE)) begin
      cin.sub = s_rdata;
    end else begin
      cin.sub = '0;
    end
    c_wdata.path = cout.path;
    c_wdata.gap  = cout.hgap;
  end

  swa_cell u_cell (
    .cell_i(cin),
    .cell_o(cout)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swa_pkg::ST_IDLE: begin
        if (in_fire && swa_pkg::mode_e'(in_if.mode) == swa_pkg::MODE_REF) begin
          state_d = (qlen_q == '0) ? swa_pkg::ST_FIN : swa_pkg::ST_RDQ;
        end
      end
      swa_pkg::ST_RDQ:  state_d = swa_pkg::ST_RDS;
      swa_pkg::ST_RDS:  state_d = swa_pkg::ST_CALC;
      swa_pkg::ST_CALC: state_d = row_last ? swa_pkg::ST_FIN : swa_pkg::ST_RDS;
      swa_pkg::ST_FIN: begin
        if (!last_q || out_free) begin
          state_d = swa_pkg::ST_IDLE;
        end
      end
      default: state_d = swa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_q     <= swa_pkg::GAP_OPEN_RST;
      gap_ext_q      <= swa_pkg::GAP_EXT_RST;
      qlen_q         <= '0;
      rows_init_q    <= '0;
      ref_pos_q      <= '0;
      best_q         <= swa_pkg::PATH_NONE;
      best_row_q     <= '0;
      best_ref_q     <= '0;
      sat_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          swa_pkg::CFG_GAP_OPEN: gap_open_q <= cfg_if.data;
          swa_pkg::CFG_GAP_EXT:  gap_ext_q  <= cfg_if.data;
          default: ;
        endcase
      end
      if (q_we) begin
        qlen_q <= qlen_q + swa_pkg::QLEN_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == swa_pkg::ST_CALC) begin
        sat_q <= sat_q | cout.sat;
        if (cout.path.score > best_q.score) begin
          best_q     <= cout.path;
          best_row_q <= row_q;
          best_ref_q <= ref_pos_q;
        end
      end
      if (state_q == swa_pkg::ST_FIN) begin
        if (!last_q) begin
          rows_init_q <= qlen_q;
          ref_pos_q   <= ref_pos_q + swa_pkg::REF_W'(1);
        end else if (emit) begin
          qlen_q       <= '0;
          rows_init_q  <= '0;
          ref_pos_q    <= '0;
          best_q       <= swa_pkg::PATH_NONE;
          best_row_q   <= '0;
          best_ref_q   <= '0;
          sat_q        <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r_q    <= in_if.residue;
      last_q <= in_if.last;
      row_q  <= '0;
      diag_q <= '0;
      up_q   <= '0;
      vgap_q <= swa_pkg::SC_MIN;
    end
    if (state_q == swa_pkg::ST_CALC) begin
      diag_q <= left.path;
      up_q   <= cout.path;
      vgap_q <= cout.vgap;
      row_q  <= row_q + swa_pkg::QIDX_W'(1);
    end
    if (emit) begin
      out_if.score        <= best_q.score;
      out_if.matches_res  <= best_q.match_cnt;
      out_if.similar      <= best_q.similar;
      out_if.align_length <= best_q.length;
      out_if.end_qpos     <= best_row_q;
      out_if.end_ref      <= best_ref_q;
      out_if.saturated    <= sat_q;
    end
  end

  assign out_if.valid = out_valid_q;

`ifndef NO_ASSERTIONS
  a_rows_init_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_init_q <= qlen_q) else $error("column rows exceed query length");

  a_calc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swa_pkg::ST_CALC) |-> ({1'b0, row_q} < qlen_q))
    else $error("cell row beyond query");

  a_calc_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swa_pkg::ST_CALC) |=>
      (state_q == swa_pkg::ST_RDS || state_q == swa_pkg::ST_FIN))
    else $error("bad state after cell");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (qlen_q == '0 && out_valid_q))
    else $error("result not loaded or query not cleared");
`endif

endmodule

FILE: tb/smith_waterman_affine_stats_core_test.sv
`timescale 1ns / 1ps

module smith_waterman_affine_stats_core_test;
  import swa_pkg::*;

  typedef struct {
    logic signed [SCORE_BITS-1:0] score;
    logic [CNT_W-1:0]             matches_res;
    logic [CNT_W-1:0]             similar;
    logic [CNT_W-1:0]             align_length;
    logic [QIDX_W-1:0]            end_qpos;
    logic [REF_W-1:0]             end_ref;
    logic                         saturated;
  } alignment_t;

  localparam logic [CODE_W-1:0] USED_CODES [4] = '{5'd0, 5'd1, 5'd2, 5'd23};
  localparam longint LIM_MAX = 64'sd32767;
  localparam longint LIM_MIN = -64'sd32768;

  class alignment_scoreboard;
    int unsigned gap_open, gap_ext;
    logic signed [SUBST_W-1:0] matrix [ALPHABET_SIZE*ALPHABET_SIZE];
    logic [CODE_W-1:0] query [MAX_QUERY];
    int     query_len, ref_pos;
    longint col_h [MAX_QUERY], col_g [MAX_QUERY];
    longint col_m [MAX_QUERY], col_s [MAX_QUERY], col_l [MAX_QUERY];
    longint best_h, best_m, best_s, best_l;
    int     best_q, best_r;
    bit     sat;
    alignment_t expected_alignments [$];
    int     errors;

    function new();
      gap_open = GAP_OPEN_RST;
      gap_ext  = GAP_EXT_RST;
      errors   = 0;
      clear_alignment();
    endfunction

    function void clear_alignment();
      query_len = 0;
      ref_pos   = 0;
      for (int i = 0; i < MAX_QUERY; i++) begin
        col_h[i] = 0; col_g[i] = LIM_MIN; col_m[i] = 0; col_s[i] = 0; col_l[i] = 0;
      end
      best_h = LIM_MIN; best_m = 0; best_s = 0; best_l = 0; best_q = 0; best_r = 0;
      sat = 0;
    endfunction

    function longint floor_min(longint v);
      return v < LIM_MIN ? LIM_MIN : v;
    endfunction

    function longint cap(longint v);
      if (v >= LIM_MAX) begin
        sat = 1;
        return LIM_MAX;
      end
      return v;
    endfunction

    function void compute_column(logic [CODE_W-1:0] r);
      longint dg_h, dg_m, dg_s, dg_l, up_h, up_m, up_s, up_l, vg;
      longint we_h, we_m, we_s, we_l, sub, dia, v, g, h, m, s, l, a, b;
      dg_h = 0; dg_m = 0; dg_s = 0; dg_l = 0;
      up_h = 0; up_m = 0; up_s = 0; up_l = 0; vg = LIM_MIN;
      for (int i = 0; i < query_len; i++) begin
        we_h = col_h[i]; we_m = col_m[i]; we_s = col_s[i]; we_l = col_l[i];
        if (query[i] < ALPHABET_SIZE && r < ALPHABET_SIZE)
          sub = matrix[query[i]*ALPHABET_SIZE + r];
        else
          sub = 0;
        dia = dg_h + sub;
        if (dia > LIM_MAX) dia = LIM_MAX;
        dia = floor_min(dia);
        a = floor_min(up_h - gap_open);
        b = floor_min(vg - gap_ext);
        v = a > b ? a : b;
        a = floor_min(we_h - gap_open);
        b = floor_min(col_g[i] - gap_ext);
        g = a > b ? a : b;
        h = dia;
        if (v > h) h = v;
        if (g > h) h = g;
        if (h < 0) h = 0;
        if (dia >= v && dia >= g) begin
          m = dg_m + (query[i] == r); s = dg_s + (sub > 0); l = dg_l + 1;
        end else if (v >= g) begin
          m = up_m; s = up_s; l = up_l + 1;
        end else begin
          m = we_m; s = we_s; l = we_l + 1;
        end
        if (h == 0) begin
          m = 0; s = 0; l = 0;
        end
        h = cap(h); m = cap(m); s = cap(s); l = cap(l);
        dg_h = we_h; dg_m = we_m; dg_s = we_s; dg_l = we_l;
        col_h[i] = h; col_g[i] = g; col_m[i] = m; col_s[i] = s; col_l[i] = l;
        up_h = h; up_m = m; up_s = s; up_l = l; vg = v;
        if (h > best_h) begin
          best_h = h; best_m = m; best_s = s; best_l = l; best_q = i; best_r = ref_pos;
        end
      end
    endfunction

    function void note_input(mode_e mode, logic [CODE_W-1:0] res, logic [CODE_W-1:0] col,
                             logic signed [SUBST_W-1:0] value, bit last);
      alignment_t e;
      case (mode)
        MODE_MATRIX: begin
          if (res < ALPHABET_SIZE && col < ALPHABET_SIZE) matrix[res*ALPHABET_SIZE + col] = value;
        end
        MODE_QUERY: begin
          if (query_len < MAX_QUERY) begin
            query[query_len] = res;
            query_len++;
          end
        end
        MODE_REF: begin
          compute_column(res);
          ref_pos = (ref_pos + 1) & 16'hFFFF;
          if (last) begin
            e.score        = SCORE_BITS'(best_h);
            e.matches_res  = CNT_W'(best_m);
            e.similar      = CNT_W'(best_s);
            e.align_length = CNT_W'(best_l);
            e.end_qpos     = QIDX_W'(best_q);
            e.end_ref      = REF_W'(best_r);
            e.saturated    = sat;
            expected_alignments.push_back(e);
            clear_alignment();
          end
        end
        default: ;
      endcase
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d", field, got, want);
      errors++;
    endtask

    task check_result(alignment_t got);
      alignment_t e;
      if (expected_alignments.size() == 0) begin
        report("result beat count", 1, 0);
        return;
      end
      e = expected_alignments.pop_front();
      if (got.score != e.score) report("score", got.score, e.score);
      if (got.matches_res != e.matches_res) report("matches_res", got.matches_res, e.matches_res);
      if (got.similar != e.similar) report("similar", got.similar, e.similar);
      if (got.align_length != e.align_length)
        report("align_length", got.align_length, e.align_length);
      if (got.end_qpos != e.end_qpos) report("end_qpos", got.end_qpos, e.end_qpos);
      if (got.end_ref != e.end_ref) report("end_ref", got.end_ref, e.end_ref);
      if (got.saturated != e.saturated) report("saturated", got.saturated, e.saturated);
    endtask
  endclass

  logic clk, rst_n;
  swa_in_if  in_if ();
  swa_out_if out_if ();
  swa_cfg_if cfg_if ();

  smith_waterman_affine_stats_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  alignment_scoreboard sb = new();
  int idle_pct = 13;
  int hold_cycles = 0;
  int sent_items = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_if.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready = 0;
        hold_cycles--;
      end else begin
        out_if.ready = ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    alignment_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.score        = out_if.score;
      got.matches_res  = out_if.matches_res;
      got.similar      = out_if.similar;
      got.align_length = out_if.align_length;
      got.end_qpos     = out_if.end_qpos;
      got.end_ref      = out_if.end_ref;
      got.saturated    = out_if.saturated;
      sb.check_result(got);
    end
  end

  task automatic send(mode_e mode, logic [CODE_W-1:0] res, logic [CODE_W-1:0] col,
                      logic [SUBST_W-1:0] value, bit last);
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 4)) @(negedge clk);
    in_if.valid        = 1;
    in_if.mode         = mode;
    in_if.residue      = res;
    in_if.matrix_col   = col;
    in_if.matrix_value = value;
    in_if.last         = last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(mode, res, col, value, last);
    sent_items++;
    @(negedge clk);
    in_if.valid = 0;
  endtask

  task automatic wait_drained();
    while (sb.expected_alignments.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAP_W-1:0] data);
    wait_drained();
    repeat (2 * MAX_QUERY + 8) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_GAP_OPEN) sb.gap_open = data;
    else sb.gap_ext = data;
    @(negedge clk);
    cfg_if.valid = 0;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(9) == 0) return CODE_W'($urandom_range(24, 31));
    return USED_CODES[$urandom_range(3)];
  endfunction

  task automatic send_noise();
    case ($urandom_range(3))
      0: send(MODE_NONE, CODE_W'($urandom), CODE_W'($urandom), SUBST_W'($urandom),
              1'($urandom));
      1: send(MODE_MATRIX, CODE_W'($urandom_range(24, 31)), CODE_W'($urandom),
              SUBST_W'($urandom), 1'($urandom));
      2: send(MODE_MATRIX, CODE_W'($urandom_range(0, 23)), CODE_W'($urandom),
              SUBST_W'($urandom), 1'($urandom));
      default: send(MODE_QUERY, pick_code(), CODE_W'($urandom), SUBST_W'($urandom),
                    1'($urandom));
    endcase
  endtask

  task automatic random_alignment(int max_len);
    int qn, rn;
    qn = $urandom_range(0, max_len);
    rn = $urandom_range(1, max_len);
    repeat ($urandom_range(0, 2))
      send(MODE_MATRIX, USED_CODES[$urandom_range(3)], USED_CODES[$urandom_range(3)],
           SUBST_W'($urandom), 1'($urandom));
    for (int i = 0; i < qn; i++) begin
      if ($urandom_range(9) == 0) send_noise();
      send(MODE_QUERY, pick_code(), CODE_W'($urandom), SUBST_W'($urandom), 1'($urandom));
    end
    for (int j = 0; j < rn; j++) begin
      if ($urandom_range(9) == 0) send_noise();
      send(MODE_REF, pick_code(), CODE_W'($urandom), SUBST_W'($urandom), j == rn - 1);
    end
  endtask

  task automatic random_phase(int items, int max_len);
    int stop_at;
    stop_at = sent_items + items;
    while (sent_items < stop_at) random_alignment(max_len);
  endtask

  initial begin
    rst_n = 0;
    in_if.valid = 0; in_if.mode = MODE_NONE; in_if.residue = 0;
    in_if.matrix_col = 0; in_if.matrix_value = 0; in_if.last = 0;
    cfg_if.valid = 0; cfg_if.index = CFG_GAP_OPEN; cfg_if.data = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (USED_CODES[a]) foreach (USED_CODES[b])
      send(MODE_MATRIX, USED_CODES[a], USED_CODES[b], SUBST_W'($urandom), 0);
    send(MODE_MATRIX, 5'd0, 5'd0, 8'sd127, 1);
    send(MODE_MATRIX, 5'd1, 5'd23, -8'sd128, 0);
    send(MODE_MATRIX, 5'd31, 5'd31, 8'sd99, 0);
    send(MODE_REF, 5'd0, 5'd0, 0, 1);
    send(MODE_QUERY, 5'd0, 5'd0, 0, 1);
    send(MODE_QUERY, 5'd23, 5'd0, 0, 0);
    send(MODE_QUERY, 5'd31, 5'd0, 0, 0);
    send(MODE_QUERY, 5'd1, 5'd0, 0, 0);
    send(MODE_REF, 5'd0, 5'd0, 0, 0);
    send(MODE_NONE, 5'd31, 5'd31, 8'hFF, 1);
    send(MODE_REF, 5'd31, 5'd0, 0, 0);
    send(MODE_QUERY, 5'd24, 5'd0, 0, 0);
    send(MODE_REF, 5'd23, 5'd0, 0, 1);

    write_reg(CFG_GAP_OPEN, 7'd127);
    write_reg(CFG_GAP_EXT, 7'd127);
    random_phase(130, 10);

    write_reg(CFG_GAP_OPEN, 7'd0);
    write_reg(CFG_GAP_EXT, 7'd0);
    idle_pct = 0;
    random_phase(130, 10);
    idle_pct = 13;

    write_reg(CFG_GAP_OPEN, GAP_W'($urandom_range(1, 20)));
    write_reg(CFG_GAP_EXT, GAP_W'($urandom_range(0, 5)));
    hold_cycles = 400;
    repeat (6) begin
      send(MODE_QUERY, pick_code(), 0, 0, 0);
      send(MODE_REF, pick_code(), 0, 0, 1);
    end
    wait_drained();
    random_phase(250, 14);

    wait_drained();
    repeat (2 * MAX_QUERY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_alignments.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
